[rtl/point_plane_distance_assert.svh]
// ----------------------------------------------------------------------------
// point_plane_distance assertion macros
// concurrent checks clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef POINT_PLANE_DISTANCE_ASSERT_SVH
`define POINT_PLANE_DISTANCE_ASSERT_SVH

// antecedent in a cycle implies consequent in the same cycle
`define PPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_plane_distance: implication check failed");

// antecedent in a cycle implies consequent in the next cycle
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_plane_distance: next cycle check failed");

`endif

[rtl/ppd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// widths, types and constants shared by the point to plane distance block
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_BITS  = 33;
  localparam int SB         = 34;                 // result bits searched

  localparam int DB   = COORD_BITS + 1;           // coordinate difference
  localparam int PB   = 2 * DB;                   // cross product term
  localparam int NB   = PB + 1;                   // normal component
  localparam int TB   = DB + NB;                  // dot product term
  localparam int DTB  = TB + 2;                   // dot product
  localparam int LB   = DTB / 2;                  // low half of |dot|
  localparam int HB   = DTB - LB;                 // high half of |dot|
  localparam int NNW  = 2 * NB + 2;               // |n|^2
  localparam int XW   = 2 * DTB + 2 * FRAC_BITS;  // dot^2 * 2^(2*frac)
  localparam int TW   = SB + NNW;                 // d * |n|^2
  localparam int CW   = ((XW > 2 * SB + NNW) ? XW : 2 * SB + NNW) + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [XW-1:0]  x;
    logic [NNW-1:0] nn;
    logic           dg;
  } ppd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ppd_fifo_stat_t;

endpackage

[rtl/point_plane_distance.sv]
// Path: an accepted word passes 7 front stages (the first loaded at the
// accepting edge), then the queue, then 34 search stages incl. output.
// Throughput: one word per cycle unless a full queue or low out_ready_i stalls.
// Reset: asynchronous active low rst_ni clears all valid bits and queue
// pointers; no clearing pass, words are accepted right after reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_plane_distance
// distance from a query point to the plane through three points, unsigned
// fixed point with FRAC_BITS fraction bits, truncated
// ----------------------------------------------------------------------------
module point_plane_distance import ppd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p1_z_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p2_z_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,
  input  logic signed [COORD_BITS-1:0] p3_z_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DIST_BITS-1:0]         distance_q16_o,
  output logic                         degenerate_o
);

  `include "point_plane_distance_assert.svh"

  ppd_fifo_stat_t fifo_stat;
  ppd_entry_t     entry, head;
  logic           push, pop;

  ppd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .p1_x_i      (p1_x_i),
    .p1_y_i      (p1_y_i),
    .p1_z_i      (p1_z_i),
    .p2_x_i      (p2_x_i),
    .p2_y_i      (p2_y_i),
    .p2_z_i      (p2_z_i),
    .p3_x_i      (p3_x_i),
    .p3_y_i      (p3_y_i),
    .p3_z_i      (p3_z_i),
    .query_x_i   (query_x_i),
    .query_y_i   (query_y_i),
    .query_z_i   (query_z_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .entry_o     (entry)
  );

  ppd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  ppd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .fifo_stat_i    (fifo_stat),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .distance_q16_o (distance_q16_o),
    .degenerate_o   (degenerate_o)
  );

  // collinear planes report zero distance
  `PPD_ASSERT_IMP(a_degen_zero, out_valid_o && degenerate_o, distance_q16_o == '0)
  // front only stalls on a full queue
  `PPD_ASSERT_IMP(a_stall_full, !in_ready_o, fifo_stat.full)
  // a push into a full queue would drop a word
  `PPD_ASSERT_IMP(a_no_overflow, push, !fifo_stat.full)
  // a pop leaves the queue not full
  `PPD_ASSERT_NEXT(a_pop_room, pop && !push, !fifo_stat.full)

endmodule

[rtl/ppd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_front
// accepts point words, forms normal, dot product and squared terms in seven
// stages and classifies collinear planes
// ----------------------------------------------------------------------------
module ppd_front import ppd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] p1_x_i,
  input  logic signed [COORD_BITS-1:0] p1_y_i,
  input  logic signed [COORD_BITS-1:0] p1_z_i,
  input  logic signed [COORD_BITS-1:0] p2_x_i,
  input  logic signed [COORD_BITS-1:0] p2_y_i,
  input  logic signed [COORD_BITS-1:0] p2_z_i,
  input  logic signed [COORD_BITS-1:0] p3_x_i,
  input  logic signed [COORD_BITS-1:0] p3_y_i,
  input  logic signed [COORD_BITS-1:0] p3_z_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  input  ppd_fifo_stat_t               fifo_stat_i,
  output logic                         push_o,
  output ppd_entry_t                   entry_o
);

  logic [6:0] v_q;
  logic       en;

  logic signed [DB-1:0]  v1_q [3];
  logic signed [DB-1:0]  w1_q [3];
  logic signed [DB-1:0]  q1_q [3];
  logic signed [PB-1:0]  pr2_q [6];
  logic signed [DB-1:0]  q2_q [3];
  logic signed [NB-1:0]  n3_q [3];
  logic signed [DB-1:0]  q3_q [3];
  logic signed [TB-1:0]  dt4_q [3];
  logic [2*NB-1:0]       sq4_q [3];
  logic                  dg4_q;
  logic signed [DTB-1:0] dot5_q;
  logic [NNW-1:0]        nn5_q;
  logic                  dg5_q;
  logic [2*HB-1:0]       hh6_q;
  logic [HB+LB-1:0]      hl6_q;
  logic [2*LB-1:0]       ll6_q;
  logic [NNW-1:0]        nn6_q;
  logic                  dg6_q;
  ppd_entry_t            e7_q;

  logic [NB-1:0]  na [3];
  logic [DTB-1:0] dabs;
  logic [HB-1:0]  dhi;
  logic [LB-1:0]  dlo;
  logic [XW-1:0]  xsum;

  assign en         = !(v_q[6] && fifo_stat_i.full);
  assign in_ready_o = en;
  assign push_o     = v_q[6] && !fifo_stat_i.full;
  assign entry_o    = e7_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      na[k] = n3_q[k][NB-1] ? unsigned'(-n3_q[k]) : unsigned'(n3_q[k]);
    end
    dabs = dot5_q[DTB-1] ? unsigned'(-dot5_q) : unsigned'(dot5_q);
    dhi  = dabs[DTB-1:LB];
    dlo  = dabs[LB-1:0];
    xsum = (XW'(hh6_q) << (2 * LB)) + (XW'(hl6_q) << (LB + 1)) + XW'(ll6_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // differences against the first plane point
      v1_q[0] <= DB'(p2_x_i) - DB'(p1_x_i);
      v1_q[1] <= DB'(p2_y_i) - DB'(p1_y_i);
      v1_q[2] <= DB'(p2_z_i) - DB'(p1_z_i);
      w1_q[0] <= DB'(p3_x_i) - DB'(p1_x_i);
      w1_q[1] <= DB'(p3_y_i) - DB'(p1_y_i);
      w1_q[2] <= DB'(p3_z_i) - DB'(p1_z_i);
      q1_q[0] <= DB'(query_x_i) - DB'(p1_x_i);
      q1_q[1] <= DB'(query_y_i) - DB'(p1_y_i);
      q1_q[2] <= DB'(query_z_i) - DB'(p1_z_i);

      // cross product terms
      pr2_q[0] <= PB'(v1_q[1]) * PB'(w1_q[2]);
      pr2_q[1] <= PB'(w1_q[1]) * PB'(v1_q[2]);
      pr2_q[2] <= PB'(v1_q[2]) * PB'(w1_q[0]);
      pr2_q[3] <= PB'(v1_q[0]) * PB'(w1_q[2]);
      pr2_q[4] <= PB'(v1_q[0]) * PB'(w1_q[1]);
      pr2_q[5] <= PB'(v1_q[1]) * PB'(w1_q[0]);
      q2_q     <= q1_q;

      n3_q[0] <= NB'(pr2_q[0]) - NB'(pr2_q[1]);
      n3_q[1] <= NB'(pr2_q[2]) - NB'(pr2_q[3]);
      n3_q[2] <= NB'(pr2_q[4]) - NB'(pr2_q[5]);
      q3_q    <= q2_q;

      for (int k = 0; k < 3; k++) begin
        dt4_q[k] <= TB'(q3_q[k]) * TB'(n3_q[k]);
        sq4_q[k] <= (2 * NB)'(na[k]) * (2 * NB)'(na[k]);
      end
      dg4_q <= (n3_q[0] == '0) && (n3_q[1] == '0) && (n3_q[2] == '0);

      dot5_q <= DTB'(dt4_q[0]) + DTB'(dt4_q[1]) + DTB'(dt4_q[2]);
      nn5_q  <= NNW'(sq4_q[0]) + NNW'(sq4_q[1]) + NNW'(sq4_q[2]);
      dg5_q  <= dg4_q;

      // dot squared from half width partial products
      hh6_q <= (2 * HB)'(dhi) * (2 * HB)'(dhi);
      hl6_q <= (HB + LB)'(dhi) * (HB + LB)'(dlo);
      ll6_q <= (2 * LB)'(dlo) * (2 * LB)'(dlo);
      nn6_q <= nn5_q;
      dg6_q <= dg5_q;

      e7_q.x  <= xsum << (2 * FRAC_BITS);
      e7_q.nn <= nn6_q;
      e7_q.dg <= dg6_q;
    end
  end

endmodule

[rtl/ppd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_fifo
// short queue decoupling the front pipeline from the root search pipeline
// ----------------------------------------------------------------------------
module ppd_fifo import ppd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ppd_entry_t     entry_i,
  input  logic           pop_i,
  output ppd_entry_t     head_o,
  output ppd_fifo_stat_t stat_o
);

  ppd_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

[rtl/ppd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_back
// pipelined bit by bit search for the largest d with d^2 * |n|^2 <= x,
// one result bit per stage; the last stage register feeds saturation and the output
// ----------------------------------------------------------------------------
module ppd_back import ppd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ppd_entry_t           head_i,
  input  ppd_fifo_stat_t       fifo_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DIST_BITS-1:0] distance_q16_o,
  output logic                 degenerate_o
);

  typedef struct packed {
    logic [CW-1:0]  rem;   // x - d^2 * nn
    logic [TW-1:0]  t;     // d * nn
    logic [NNW-1:0] nn;
    logic [SB-1:0]  d;
    logic           dg;
  } stage_t;

  stage_t        st_q [SB];
  stage_t        st_d [SB];
  stage_t        src;
  logic [SB-1:0] v_q;
  logic          en;
  logic [CW-1:0] inc;
  stage_t        last;

  assign en    = !v_q[SB-1] || out_ready_i;
  assign pop_o = en && !fifo_stat_i.empty;

  always_comb begin
    for (int i = 0; i < SB; i++) begin
      if (i == 0) begin
        src.rem = CW'(head_i.x);
        src.t   = '0;
        src.nn  = head_i.nn;
        src.d   = '0;
        src.dg  = head_i.dg;
      end else begin
        src = st_q[i-1];
      end
      // cost of setting bit b: (2^(b+1) * d + 2^(2b)) * nn
      inc     = (CW'(src.t) << (SB - i)) + (CW'(src.nn) << (2 * (SB - 1 - i)));
      st_d[i] = src;
      if (inc <= src.rem) begin
        st_d[i].rem = src.rem - inc;
        st_d[i].t   = src.t + (TW'(src.nn) << (SB - 1 - i));
        st_d[i].d   = src.d | (SB'(1) << (SB - 1 - i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[SB-2:0], !fifo_stat_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < SB; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign last         = st_q[SB-1];
  assign out_valid_o  = v_q[SB-1];
  assign degenerate_o = last.dg;

  always_comb begin
    if (last.dg) begin
      distance_q16_o = '0;
    end else if (last.d > SB'({DIST_BITS{1'b1}})) begin
      distance_q16_o = '1;
    end else begin
      distance_q16_o = last.d[DIST_BITS-1:0];
    end
  end

endmodule
